// ===== rtl/core/phist_pkg.sv =====
// Shared types, constants and register codes for the 2-D position histogram.
// No dependencies; every other file of the block but phist_if refers to this package.
package phist_pkg;

  localparam int MAP_COLUMNS_DEF = 64;
  localparam int MAP_ROWS_DEF    = 64;
  localparam int COUNT_BITS_DEF  = 32;

  // Column and row indexes travel at the widest map size (1024).
  localparam int IDX_W = 10;

  localparam int Q_DEPTH = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SNAPSHOT = 3'd6;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic signed [31:0] left_x;
    logic signed [31:0] top_y;
    logic signed [31:0] right_x;
    logic signed [31:0] bottom_y;
    logic [31:0]        scale_x;
    logic [31:0]        scale_y;
    logic               snapshot_mode;
  } cfg_t;

  // One classified operation handed from the front to the back.
  // live: sample counted, or read that falls inside the map.
  typedef struct packed {
    logic             is_read;
    logic             live;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } op_t;

endpackage

// ===== rtl/core/phist_if.sv =====
// Valid/ready channel interfaces for the histogram's input and result words.
// No dependencies.
interface phist_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic [5:0]         bin_x;
  logic [5:0]         bin_y;

  modport source(output valid, cmd, coord_x, coord_y, bin_x, bin_y, input ready);
  modport sink(input valid, cmd, coord_x, coord_y, bin_x, bin_y, output ready);
endinterface

interface phist_out_if;
  logic        valid;
  logic        ready;
  logic        in_range;
  logic [31:0] bin_count;
  logic [31:0] sample_total;

  modport source(output valid, in_range, bin_count, sample_total, input ready);
  modport sink(input valid, in_range, bin_count, sample_total, output ready);
endinterface

// ===== rtl/core/phist_front.sv =====
// Front end: accepts words, tests the rectangle, scales offsets to bin indexes.
// Depends on phist_pkg and phist_in_if.
module phist_front #(
  parameter int MAP_COLUMNS = phist_pkg::MAP_COLUMNS_DEF,
  parameter int MAP_ROWS    = phist_pkg::MAP_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  phist_in_if.sink          in_ch,
  input  phist_pkg::cfg_t   cfg,
  input  logic              hold,
  output phist_pkg::op_t    push_op,
  output logic              push_valid,
  input  logic              push_ready
);

  localparam int IW = phist_pkg::IDX_W;

  // stage 1: rectangle test and offsets
  logic          f1_valid;
  logic          f1_is_read;
  logic          f1_live;
  logic [31:0]   f1_off_x;
  logic [31:0]   f1_off_y;
  logic [IW-1:0] f1_col;
  logic [IW-1:0] f1_row;

  // stage 2: scaled indexes (integer part of offset * scale)
  logic          f2_valid;
  logic          f2_is_read;
  logic          f2_live;
  logic [31:0]   f2_idx_x;
  logic [31:0]   f2_idx_y;
  logic [IW-1:0] f2_col;
  logic [IW-1:0] f2_row;

  logic        f1_free;
  logic        f2_free;
  logic        take;
  logic        in_rect;
  logic        on_map;
  logic [63:0] prod_x;
  logic [63:0] prod_y;

  assign f2_free     = !f2_valid || push_ready;
  assign f1_free     = !f1_valid || f2_free;
  assign in_ch.ready = !hold && f1_free;
  assign take        = in_ch.valid && in_ch.ready;

  assign in_rect = ($signed(in_ch.coord_x) > $signed(cfg.left_x))  &&
                   ($signed(in_ch.coord_x) < $signed(cfg.right_x)) &&
                   ($signed(in_ch.coord_y) > $signed(cfg.top_y))   &&
                   ($signed(in_ch.coord_y) < $signed(cfg.bottom_y));

  assign on_map = (16'(in_ch.bin_x) < 16'(MAP_COLUMNS)) &&
                  (16'(in_ch.bin_y) < 16'(MAP_ROWS));

  assign prod_x = {32'b0, f1_off_x} * {32'b0, cfg.scale_x};
  assign prod_y = {32'b0, f1_off_y} * {32'b0, cfg.scale_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_free) begin
        f1_valid <= take;
      end
      if (f2_free) begin
        f2_valid <= f1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f1_is_read <= (in_ch.cmd == phist_pkg::CMD_READ);
      f1_live    <= (in_ch.cmd == phist_pkg::CMD_READ) ? on_map : in_rect;
      // offset is 1 .. 2^32-2 when inside, so the wrapped difference is exact
      f1_off_x   <= in_ch.coord_x - cfg.left_x;
      f1_off_y   <= in_ch.coord_y - cfg.top_y;
      f1_col     <= IW'(in_ch.bin_x);
      f1_row     <= IW'(in_ch.bin_y);
    end
    if (f1_valid && f2_free) begin
      f2_is_read <= f1_is_read;
      f2_live    <= f1_live;
      f2_idx_x   <= prod_x[63:32];
      f2_idx_y   <= prod_y[63:32];
      f2_col     <= f1_col;
      f2_row     <= f1_row;
    end
  end

  // clamp sample indexes to the last column or row; reads pass their bin indexes
  always_comb begin
    push_op.is_read = f2_is_read;
    push_op.live    = f2_live;
    if (f2_is_read) begin
      push_op.col = f2_col;
      push_op.row = f2_row;
    end else begin
      push_op.col = (f2_idx_x > 32'(MAP_COLUMNS - 1)) ? IW'(MAP_COLUMNS - 1) : IW'(f2_idx_x);
      push_op.row = (f2_idx_y > 32'(MAP_ROWS - 1)) ? IW'(MAP_ROWS - 1) : IW'(f2_idx_y);
    end
  end

  assign push_valid = f2_valid;

endmodule

// ===== rtl/core/phist_queue.sv =====
// Short FIFO of classified operations between the front and back ends.
// Depends on phist_pkg.
module phist_queue (
  input  logic           clk,
  input  logic           rst,
  input  phist_pkg::op_t push_op,
  input  logic           push_valid,
  output logic           push_ready,
  output phist_pkg::op_t pop_op,
  output logic           pop_valid,
  input  logic           pop_ready
);

  localparam int DEPTH = phist_pkg::Q_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  phist_pkg::op_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

// ===== rtl/core/phist_back.sv =====
// Back end: bin count memory with read-modify-write, sample total, result register.
// Depends on phist_pkg and phist_out_if.
module phist_back #(
  parameter int MAP_COLUMNS = phist_pkg::MAP_COLUMNS_DEF,
  parameter int MAP_ROWS    = phist_pkg::MAP_ROWS_DEF,
  parameter int COUNT_BITS  = phist_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  phist_pkg::op_t pop_op,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  logic           snapshot_mode,
  phist_out_if.source    out_ch,
  output logic           clearing
);

  localparam int CW = $clog2(MAP_COLUMNS);
  localparam int RW = $clog2(MAP_ROWS);
  localparam int AW = CW + RW;
  localparam int SW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  logic [COUNT_BITS-1:0] mem [2**AW];

  logic [AW-1:0]         clr_addr;

  logic                  b_valid;
  phist_pkg::op_t        b_op;
  logic [COUNT_BITS-1:0] rdata;

  logic                  fwd_valid;
  logic [AW-1:0]         fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;

  logic [31:0]           total;
  logic [31:0]           total_next;

  logic                  out_valid;
  logic                  adv;
  logic                  pop;
  logic                  wr_en;
  logic [AW-1:0]         pop_addr;
  logic [AW-1:0]         b_addr;
  logic [COUNT_BITS-1:0] old;
  logic [COUNT_BITS-1:0] inc;
  logic [COUNT_BITS-1:0] sel;
  logic [SW-1:0]         sel_ext;
  logic [31:0]           shown;

  assign pop_addr = {pop_op.col[CW-1:0], pop_op.row[RW-1:0]};
  assign b_addr   = {b_op.col[CW-1:0], b_op.row[RW-1:0]};

  assign adv       = b_valid && (!out_valid || out_ch.ready);
  assign pop_ready = !clearing && (!b_valid || adv);
  assign pop       = pop_valid && pop_ready;
  assign wr_en     = adv && !b_op.is_read && b_op.live;

  // a write at the same edge as this word's read is missed by the memory
  assign old = (fwd_valid && fwd_addr == b_addr) ? fwd_data : rdata;
  assign inc = (old == '1) ? old : old + 1'b1;
  assign sel = b_op.is_read ? old : inc;

  assign sel_ext = SW'(sel);
  assign shown   = (sel_ext > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : sel_ext[31:0];

  always_comb begin
    if (snapshot_mode) begin
      total_next = 32'd1;
    end else if (total == 32'hFFFF_FFFF) begin
      total_next = total;
    end else begin
      total_next = total + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[b_addr] <= inc;
    end
    if (pop) begin
      rdata <= mem[pop_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        b_valid <= 1'b1;
      end else if (adv) begin
        b_valid <= 1'b0;
      end
      if (clearing) begin
        fwd_valid <= 1'b0;
      end else if (wr_en) begin
        fwd_valid <= 1'b1;
      end
      if (adv && !b_op.is_read) begin
        total <= total_next;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_op <= pop_op;
    end
    if (wr_en) begin
      fwd_addr <= b_addr;
      fwd_data <= inc;
    end
    if (adv) begin
      out_ch.in_range     <= !b_op.is_read && b_op.live;
      out_ch.bin_count    <= b_op.live ? shown : 32'd0;
      out_ch.sample_total <= b_op.is_read ? total : total_next;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ===== rtl/core/position_histogram_2d_top.sv =====
// Top level of the 2-D position histogram: configuration registers and the
// front, queue and back ends. Depends on phist_pkg, phist_if and all phist_* modules.
//
// Takes one word per cycle, sample or read, while the output is not stalled and
// no clearing pass runs, and returns one result word per input word, in order,
// through two front stages (rectangle test, then the 32x32 scale multiply with
// clamp), the four-entry queue, the bin memory read, then the output register.
// The bin memory does one read-modify-write per cycle while the output is not
// stalled, with a bypass of the last write for back-to-back hits on one bin.
// After reset a clearing pass zeroes the memory, one entry per cycle, across all
// 2**(clog2(MAP_COLUMNS) + clog2(MAP_ROWS)) entries (4096 at the default 64 x 64);
// no input word is taken during it, while configuration writes are. Write
// configuration only while the block is idle.
module position_histogram_2d_top #(
  parameter int MAP_COLUMNS = phist_pkg::MAP_COLUMNS_DEF,
  parameter int MAP_ROWS    = phist_pkg::MAP_ROWS_DEF,
  parameter int COUNT_BITS  = phist_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  phist_in_if.sink                         in_ch,
  phist_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [phist_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [phist_pkg::CFG_DATA_W-1:0] cfg_data
);

  phist_pkg::cfg_t cfg;
  phist_pkg::op_t  push_op;
  phist_pkg::op_t  pop_op;
  logic            push_valid;
  logic            push_ready;
  logic            pop_valid;
  logic            pop_ready;
  logic            clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phist_pkg::REG_LEFT_X:   cfg.left_x        <= cfg_data;
        phist_pkg::REG_TOP_Y:    cfg.top_y         <= cfg_data;
        phist_pkg::REG_RIGHT_X:  cfg.right_x       <= cfg_data;
        phist_pkg::REG_BOTTOM_Y: cfg.bottom_y      <= cfg_data;
        phist_pkg::REG_SCALE_X:  cfg.scale_x       <= cfg_data;
        phist_pkg::REG_SCALE_Y:  cfg.scale_y       <= cfg_data;
        phist_pkg::REG_SNAPSHOT: cfg.snapshot_mode <= cfg_data[0];
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  phist_front #(
    .MAP_COLUMNS(MAP_COLUMNS),
    .MAP_ROWS   (MAP_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .hold      (clearing),
    .push_op   (push_op),
    .push_valid(push_valid),
    .push_ready(push_ready)
  );

  phist_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_op   (push_op),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_op    (pop_op),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready)
  );

  phist_back #(
    .MAP_COLUMNS(MAP_COLUMNS),
    .MAP_ROWS   (MAP_ROWS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_op       (pop_op),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .snapshot_mode(cfg.snapshot_mode),
    .out_ch       (out_ch),
    .clearing     (clearing)
  );

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ch.ready)
    else $error("input word taken during memory clearing pass");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop_ready)
    else $error("queue popped during memory clearing pass");

  a_hit_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.in_range) |-> (out_ch.bin_count != 32'd0))
    else $error("counted sample returned a zero bin count");

endmodule
